[rtl/nsc_pkg.sv]
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and clip codes for the number-to-speech clip sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

    localparam int unsigned EVENT_W   = 32;
    localparam int unsigned CLIP_W    = 5;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned NUM_GROUPS = 4;
    localparam int unsigned GRP_W     = 2;
    localparam int unsigned DIGITS_PER_GROUP = 3;

    localparam logic [CLIP_W-1:0] CLIP_TEN      = 5'd10;
    localparam logic [CLIP_W-1:0] CLIP_HUNDRED  = 5'd11;
    localparam logic [CLIP_W-1:0] CLIP_TENS     = 5'd12;
    localparam logic [CLIP_W-1:0] CLIP_MOT      = 5'd13;
    localparam logic [CLIP_W-1:0] CLIP_LAM      = 5'd14;
    localparam logic [CLIP_W-1:0] CLIP_GROUP0   = 5'd15;
    localparam logic [CLIP_W-1:0] CLIP_CURRENCY = 5'd18;
    localparam logic [CLIP_W-1:0] CLIP_STATUS0  = 5'd19;
    localparam logic [CLIP_W-1:0] CLIP_CHIME    = 5'd24;
    localparam logic [CLIP_W-1:0] CLIP_CREDITED = 5'd25;

    typedef logic [3:0] bcd_digit_t;
    typedef bcd_digit_t [DIGITS_PER_GROUP-1:0] bcd_group_t;
    typedef bcd_group_t [NUM_GROUPS-1:0] bcd_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STATUS,
        ST_CONV,
        ST_CHIME,
        ST_CREDITED,
        ST_GRP_H,
        ST_HUNDRED,
        ST_GRP_T,
        ST_TENS_SUFFIX,
        ST_UNIT,
        ST_GROUP_WORD,
        ST_CURRENCY
    } seq_state_t;

endpackage

`default_nettype wire

[rtl/number_to_speech_clip_sequencer_core.sv]
// ----------------------------------------------------------------------------
// number_to_speech_clip_sequencer_core
// Turns one announcement event into the run of voice-clip codes to play.
// ----------------------------------------------------------------------------
// Status events: one clip, then ready again once that clip is loaded into the output register.
// Amounts: binary to BCD conversion in one iterative shift-and-adjust unit, then
// the group steps; each clip leaves the output register one per cycle when the
// sink is ready. One request is in work at a time.
// Reset clears the sequencer and output valid.
`default_nettype none

module number_to_speech_clip_sequencer_core #(
    parameter int unsigned EVENT_W = nsc_pkg::EVENT_W
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [EVENT_W-1:0]  s_axis_tdata,   // [31:0] event_value
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [nsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [4:0] clip_id, [7:5] zero
    output logic                     m_axis_tlast    // last_clip
);

    localparam int unsigned CW = nsc_pkg::CLIP_W;

    nsc_pkg::seq_state_t state_reg, state_next;
    logic [nsc_pkg::GRP_W-1:0] grp_reg, grp_next;
    logic [CW-1:0]   status_reg, status_next;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   out_clip_reg, out_clip_next;
    logic            out_last_reg, out_last_next;

    logic            emit;
    logic [CW-1:0]   emit_clip;
    logic            emit_last;
    logic            out_load;
    logic            advance;

    logic            conv_start;
    logic            conv_done;
    nsc_pkg::bcd_word_t bcd;
    nsc_pkg::bcd_group_t cur;
    nsc_pkg::bcd_digit_t dig_h, dig_t, dig_u;
    logic            is_status;
    logic [2:0]      neg_low;
    logic            accept;

    nsc_bcd_conv #(
        .BIN_W (EVENT_W)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (s_axis_tdata),
        .done  (conv_done),
        .bcd   (bcd)
    );

    assign cur   = bcd[grp_reg];
    assign dig_h = cur[2];
    assign dig_t = cur[1];
    assign dig_u = cur[0];

    assign s_axis_tready = (state_reg == nsc_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_status     = (s_axis_tdata == '0) || (&s_axis_tdata[EVENT_W-1:2]);
    assign neg_low       = 3'(~s_axis_tdata[2:0] + 3'd1);
    assign conv_start    = accept && !is_status;

    // Outputs of the sequencer: the clip of the current step, if any
    always_comb
    begin
        emit      = 1'b0;
        emit_clip = '0;
        emit_last = 1'b0;
        case (state_reg)
            nsc_pkg::ST_STATUS:
            begin
                emit      = 1'b1;
                emit_clip = status_reg;
                emit_last = 1'b1;
            end
            nsc_pkg::ST_CHIME:
            begin
                emit      = 1'b1;
                emit_clip = nsc_pkg::CLIP_CHIME;
            end
            nsc_pkg::ST_CREDITED:
            begin
                emit      = 1'b1;
                emit_clip = nsc_pkg::CLIP_CREDITED;
            end
            nsc_pkg::ST_GRP_H:
            begin
                emit      = (dig_h != '0);
                emit_clip = CW'(dig_h);
            end
            nsc_pkg::ST_HUNDRED:
            begin
                emit      = 1'b1;
                emit_clip = nsc_pkg::CLIP_HUNDRED;
            end
            nsc_pkg::ST_GRP_T:
            begin
                emit      = (dig_t != '0);
                emit_clip = (dig_t == 4'd1) ? nsc_pkg::CLIP_TEN : CW'(dig_t);
            end
            nsc_pkg::ST_TENS_SUFFIX:
            begin
                emit      = 1'b1;
                emit_clip = nsc_pkg::CLIP_TENS;
            end
            nsc_pkg::ST_UNIT:
            begin
                emit = (dig_u != '0);
                if (dig_u == 4'd1 && dig_t > 4'd1)
                begin
                    emit_clip = nsc_pkg::CLIP_MOT;
                end
                else if (dig_u == 4'd5 && dig_t != '0)
                begin
                    emit_clip = nsc_pkg::CLIP_LAM;
                end
                else
                begin
                    emit_clip = CW'(dig_u);
                end
            end
            nsc_pkg::ST_GROUP_WORD:
            begin
                emit      = (grp_reg != '0);
                emit_clip = nsc_pkg::CLIP_GROUP0 + CW'(grp_reg) - 1'b1;
            end
            nsc_pkg::ST_CURRENCY:
            begin
                emit      = 1'b1;
                emit_clip = nsc_pkg::CLIP_CURRENCY;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign out_load = emit && (!out_valid_reg || m_axis_tready);
    assign advance  = !emit || out_load;

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        grp_next    = grp_reg;
        status_next = status_reg;
        case (state_reg)
            nsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_status)
                    begin
                        status_next = nsc_pkg::CLIP_STATUS0 + CW'(neg_low);
                        state_next  = nsc_pkg::ST_STATUS;
                    end
                    else
                    begin
                        state_next = nsc_pkg::ST_CONV;
                    end
                end
            end
            nsc_pkg::ST_STATUS:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_IDLE;
                end
            end
            nsc_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    grp_next   = nsc_pkg::GRP_W'(nsc_pkg::NUM_GROUPS - 1);
                    state_next = nsc_pkg::ST_CHIME;
                end
            end
            nsc_pkg::ST_CHIME:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_CREDITED;
                end
            end
            nsc_pkg::ST_CREDITED:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_GRP_H;
                end
            end
            nsc_pkg::ST_GRP_H:
            begin
                if (cur == '0)
                begin
                    if (grp_reg == '0)
                    begin
                        state_next = nsc_pkg::ST_CURRENCY;
                    end
                    else
                    begin
                        grp_next = grp_reg - 1'b1;
                    end
                end
                else if (advance)
                begin
                    state_next = emit ? nsc_pkg::ST_HUNDRED : nsc_pkg::ST_GRP_T;
                end
            end
            nsc_pkg::ST_HUNDRED:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_GRP_T;
                end
            end
            nsc_pkg::ST_GRP_T:
            begin
                if (advance)
                begin
                    state_next = (dig_t > 4'd1) ? nsc_pkg::ST_TENS_SUFFIX : nsc_pkg::ST_UNIT;
                end
            end
            nsc_pkg::ST_TENS_SUFFIX:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_UNIT;
                end
            end
            nsc_pkg::ST_UNIT:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_GROUP_WORD;
                end
            end
            nsc_pkg::ST_GROUP_WORD:
            begin
                if (grp_reg == '0)
                begin
                    state_next = nsc_pkg::ST_CURRENCY;
                end
                else if (advance)
                begin
                    grp_next   = grp_reg - 1'b1;
                    state_next = nsc_pkg::ST_GRP_H;
                end
            end
            nsc_pkg::ST_CURRENCY:
            begin
                if (advance)
                begin
                    state_next = nsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load a new clip or drop the taken one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_clip_next  = out_clip_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_clip_next  = emit_clip;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nsc_pkg::ST_IDLE;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_clip_reg <= out_clip_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = nsc_pkg::OUT_TDATA_W'(out_clip_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/nsc_bcd_conv.sv]
// ----------------------------------------------------------------------------
// nsc_bcd_conv
// Iterative binary to BCD converter: one shift-and-adjust step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_bcd_conv #(
    parameter int unsigned BIN_W = nsc_pkg::EVENT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [BIN_W-1:0]  value,
    output logic                   done,
    output nsc_pkg::bcd_word_t     bcd
);

    localparam int unsigned CNT_W = $clog2(BIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_W - 1);
    localparam int unsigned NIB = nsc_pkg::NUM_GROUPS * nsc_pkg::DIGITS_PER_GROUP;

    logic [BIN_W-1:0]    bin_reg, bin_next;
    nsc_pkg::bcd_word_t  bcd_reg, bcd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4*NIB-1:0]    bcd_flat;
    logic [4*NIB-1:0]    adj;

    assign bcd_flat = bcd_reg;

    always_comb
    begin
        for (int i = 0; i < NIB; i++)
        begin
            adj[4*i +: 4] = (bcd_flat[4*i +: 4] >= 4'd5) ? bcd_flat[4*i +: 4] + 4'd3
                                                          : bcd_flat[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[4*NIB-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire
